[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define ASSERT_TOP(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[hdl/vbbs_pkg.sv]
`default_nettype none

package vbbs_pkg;

  localparam int MaxDim  = 256;
  localparam int PosW    = $clog2(MaxDim);
  localparam int DimW    = $clog2(MaxDim + 1);
  localparam int SizeW   = 9;
  localparam int CfgIdxW = 2;
  localparam int VoxW    = 8;
  localparam int SizeRst = 8;

  localparam logic [VoxW-1:0] StateMask = VoxW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSizeX = 2'd0,
    CfgSizeY = 2'd1,
    CfgSizeZ = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [DimW-1:0] z;
  } dims_t;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [PosW-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [PosW-1:0] min_x;
    logic [PosW-1:0] max_x;
    logic [PosW-1:0] min_y;
    logic [PosW-1:0] max_y;
    logic [PosW-1:0] min_z;
    logic [PosW-1:0] max_z;
  } box_t;

  // One voxel moving from the input register into the result register.
  typedef struct packed {
    logic step;
    logic filled;
    logic last;
  } scan_ctrl_t;

  // Clamp a written size into 1..MaxDim.
  function automatic logic [DimW-1:0] eff_size(logic [SizeW-1:0] s);
    logic [DimW-1:0] r;
    if (s == '0) begin
      r = DimW'(1);
    end else if (int'(s) > MaxDim) begin
      r = DimW'(MaxDim);
    end else begin
      r = DimW'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/voxel_bounding_box_scan.sv]
// A voxel word passes the input register and then the result register to reach the output ports.
// Throughput: one voxel word per cycle while out_stall_i is low; set by the counter and
//   min/max update between the input register and the result register.
// Reset (rst_ni low, async): pipeline empty, sizes 8x8x8, position 0, box cleared.
// After the word marked last the scan state clears and a new volume begins.
`default_nettype none

module voxel_bounding_box_scan import vbbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [SizeW-1:0]    cfg_data_i,
  // voxel input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [VoxW-1:0]     voxel_byte_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VoxW-1:0]     cleaned_voxel_o,
  output logic                last_o,
  output logic                volume_empty_o,
  output logic [PosW-1:0]     min_x_o,
  output logic [PosW-1:0]     max_x_o,
  output logic [PosW-1:0]     min_y_o,
  output logic [PosW-1:0]     max_y_o,
  output logic [PosW-1:0]     min_z_o,
  output logic [PosW-1:0]     max_z_o
);

  // Input register: holds one voxel word until the result register is free.
  logic            in_valid_q, in_valid_d;
  logic [VoxW-1:0] byte_q;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic [VoxW-1:0] voxel_q, voxel_d;
  logic            last_q, last_d;
  logic            empty_q, empty_d;
  box_t            box_q, box_d;

  logic       out_ready;
  logic       fire;
  logic       in_accept;
  dims_t      dims;
  pos_t       pos;
  logic       pos_last;
  box_t       box_nxt;
  logic       seen_nxt;
  scan_ctrl_t ctrl;

  // The result register frees up when empty or when its word is taken, so a
  // new word can enter while the previous result is still being delivered.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  vbbs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .dims_o     (dims)
  );

  // Position counters advance once per voxel moved into the result register.
  vbbs_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .dims_i (dims),
    .pos_o  (pos),
    .last_o (pos_last)
  );

  assign ctrl.step   = fire;
  assign ctrl.filled = (byte_q & StateMask) != '0;
  assign ctrl.last   = pos_last;

  vbbs_box u_box (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .pos_i  (pos),
    .box_o  (box_nxt),
    .seen_o (seen_nxt)
  );

  // Result word: empty voxels lose their color; the box is only shown on last.
  assign voxel_d = ctrl.filled ? byte_q : '0;
  assign last_d  = pos_last;
  assign empty_d = pos_last && !seen_nxt;
  assign box_d   = (pos_last && seen_nxt) ? box_nxt : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= voxel_byte_i;
    end
    if (fire) begin
      voxel_q <= voxel_d;
      last_q  <= last_d;
      empty_q <= empty_d;
      box_q   <= box_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cleaned_voxel_o = voxel_q;
  assign last_o          = last_q;
  assign volume_empty_o  = empty_q;
  assign min_x_o         = box_q.min_x;
  assign max_x_o         = box_q.max_x;
  assign min_y_o         = box_q.min_y;
  assign max_y_o         = box_q.max_y;
  assign min_z_o         = box_q.min_z;
  assign max_z_o         = box_q.max_z;

endmodule

`default_nettype wire

[hdl/vbbs_cfg.sv]
`default_nettype none

module vbbs_cfg import vbbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [SizeW-1:0]    cfg_data_i,
  output dims_t               dims_o
);

  dims_t dims_q, dims_d;

  // Sizes are stored already clamped.
  always_comb begin
    dims_d = dims_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSizeX: dims_d.x = eff_size(cfg_data_i);
        CfgSizeY: dims_d.y = eff_size(cfg_data_i);
        CfgSizeZ: dims_d.z = eff_size(cfg_data_i);
        default:  dims_d = dims_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.x <= DimW'(SizeRst);
      dims_q.y <= DimW'(SizeRst);
      dims_q.z <= DimW'(SizeRst);
    end else begin
      dims_q <= dims_d;
    end
  end

  assign dims_o = dims_q;

endmodule

`default_nettype wire

[hdl/vbbs_pos.sv]
`default_nettype none

module vbbs_pos import vbbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  dims_t dims_i,
  output pos_t  pos_o,
  output logic  last_o
);

  pos_t pos_q, pos_d;
  logic end_x, end_y, end_z;

  // A counter at or past its size minus one wraps on its next step.
  assign end_x  = (DimW'(pos_q.x) + DimW'(1)) >= dims_i.x;
  assign end_y  = (DimW'(pos_q.y) + DimW'(1)) >= dims_i.y;
  assign end_z  = (DimW'(pos_q.z) + DimW'(1)) >= dims_i.z;
  assign last_o = end_x & end_y & end_z;

  always_comb begin
    pos_d = pos_q;
    if (step_i) begin
      if (last_o) begin
        pos_d = '0;
      end else if (!end_x) begin
        pos_d.x = pos_q.x + PosW'(1);
      end else begin
        pos_d.x = '0;
        if (!end_y) begin
          pos_d.y = pos_q.y + PosW'(1);
        end else begin
          pos_d.y = '0;
          pos_d.z = pos_q.z + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

`default_nettype wire

[hdl/vbbs_box.sv]
`default_nettype none

module vbbs_box import vbbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_ctrl_t ctrl_i,
  input  pos_t       pos_i,
  output box_t       box_o,
  output logic       seen_o
);

  box_t box_q, box_nxt, box_rst;
  logic seen_q, seen_nxt;

  always_comb begin
    box_rst       = '0;
    box_rst.min_x = '1;
    box_rst.min_y = '1;
    box_rst.min_z = '1;
  end

  // Box including the voxel now in flight.
  always_comb begin
    box_nxt  = box_q;
    seen_nxt = seen_q;
    if (ctrl_i.filled) begin
      seen_nxt = 1'b1;
      if (!seen_q) begin
        box_nxt = '{pos_i.x, pos_i.x, pos_i.y, pos_i.y, pos_i.z, pos_i.z};
      end else begin
        if (pos_i.x < box_q.min_x) box_nxt.min_x = pos_i.x;
        if (pos_i.x > box_q.max_x) box_nxt.max_x = pos_i.x;
        if (pos_i.y < box_q.min_y) box_nxt.min_y = pos_i.y;
        if (pos_i.y > box_q.max_y) box_nxt.max_y = pos_i.y;
        if (pos_i.z < box_q.min_z) box_nxt.min_z = pos_i.z;
        if (pos_i.z > box_q.max_z) box_nxt.max_z = pos_i.z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q  <= box_rst;
      seen_q <= 1'b0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.last) begin
        box_q  <= box_rst;
        seen_q <= 1'b0;
      end else begin
        box_q  <= box_nxt;
        seen_q <= seen_nxt;
      end
    end
  end

  assign box_o  = box_nxt;
  assign seen_o = seen_nxt;

endmodule

`default_nettype wire

[hdl/vbbs_chk.sv]
`default_nettype none

`include "assert_macros.svh"

module vbbs_chk import vbbs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [VoxW-1:0]     cleaned_voxel_o,
  input logic                last_o,
  input logic                volume_empty_o,
  input logic [PosW-1:0]     min_x_o,
  input logic [PosW-1:0]     max_x_o,
  input logic [PosW-1:0]     min_y_o,
  input logic [PosW-1:0]     max_y_o,
  input logic [PosW-1:0]     min_z_o,
  input logic [PosW-1:0]     max_z_o
);

  logic box_zero;

  assign box_zero = (min_x_o == '0) && (max_x_o == '0) && (min_y_o == '0) &&
                    (max_y_o == '0) && (min_z_o == '0) && (max_z_o == '0);

  `ASSERT_TOP(a_out_valid_holds, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped while stalled")

  `ASSERT_TOP(a_mid_volume_clear, (out_valid_o && !last_o) |-> (!volume_empty_o && box_zero), "box fields set on a word that is not last")

  `ASSERT_TOP(a_empty_means_zero_box, (out_valid_o && volume_empty_o) |-> (last_o && box_zero), "empty volume with a nonzero box")

  `ASSERT_TOP(a_cleaned_not_empty, (out_valid_o && (cleaned_voxel_o != '0)) |-> ((cleaned_voxel_o & StateMask) != '0), "empty voxel passed with color")

  `ASSERT_TOP(a_box_ordered, (out_valid_o && last_o && !volume_empty_o) |-> ((min_x_o <= max_x_o) && (min_y_o <= max_y_o) && (min_z_o <= max_z_o)), "box minimum above maximum")

endmodule

bind voxel_bounding_box_scan vbbs_chk u_vbbs_chk (.*);

`default_nettype wire
